/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/fge_pkg.sv */
// ----------------------------------------------------------------------------
// fge_pkg
// Shared constants, types and helpers of the frontier grid explorer.
// ----------------------------------------------------------------------------
package fge_pkg;

    localparam int GRID_CELLS = 16;
    localparam int GRID_BITS  = $clog2(GRID_CELLS);
    localparam int NUM_CELLS  = GRID_CELLS * GRID_CELLS;
    localparam int ADDR_W     = 2 * GRID_BITS;
    localparam int FRAC_BITS  = 8;
    localparam int HALF_GRID  = (GRID_CELLS << FRAC_BITS) / 2;

    localparam int POS_W  = 16;
    localparam int FOV_W  = 15;
    localparam int CNT_W  = 9;
    localparam int EXT_W  = POS_W + 2;        // origin / target sums before saturation
    localparam int DIFF_W = 19;               // pos +/- fov - origin
    localparam int CELL_W = DIFF_W - FRAC_BITS;
    localparam int DIST_W = 2 * CELL_W;

    localparam int IN_W  = 2 * POS_W;
    localparam int OUT_W = 48;                // tx, ty, complete, count, zero fill

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FOV_HALF_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FOV_HALF_Y = CFG_IDX_W'(1);

    localparam logic [FOV_W-1:0] FOV_HALF_X_RST = FOV_W'(668);
    localparam logic [FOV_W-1:0] FOV_HALF_Y_RST = FOV_W'(501);

    localparam logic signed [CELL_W-1:0] CELL_MAX = CELL_W'(GRID_CELLS - 1);

    typedef enum logic [1:0] {
        CELL_UNEXPLORED,
        CELL_EXPLORED,
        CELL_BORDER
    } t_cell;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_BOUND,
        S_CLAMP,
        S_RECT_RD,
        S_RECT_WR,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic bound;
        logic clamp;
        logic rect_rd;
        logic rect_wr;
        logic scan_rd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic fresh;
        logic idx_last;
        logic overlap;
        logic rect_last;
        logic out_free;
    } t_dp_status;

    // fixed point to cell index, truncating toward zero
    function automatic logic signed [CELL_W-1:0] to_cell(input logic signed [DIFF_W-1:0] d);
        logic signed [DIFF_W-1:0] q;
        q = d >>> FRAC_BITS;
        if (d[DIFF_W-1] && (d[FRAC_BITS-1:0] != '0)) begin
            q = q + {{(DIFF_W-1){1'b0}}, 1'b1};
        end
        return q[CELL_W-1:0];
    endfunction

    function automatic logic [GRID_BITS-1:0] clamp_idx(input logic signed [CELL_W-1:0] c);
        logic [GRID_BITS-1:0] r;
        if (c[CELL_W-1]) begin
            r = '0;
        end else if (c > CELL_MAX) begin
            r = GRID_BITS'(GRID_CELLS - 1);
        end else begin
            r = c[GRID_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic [EXT_W-1:0] v);
        logic [POS_W-1:0] r;
        if ((v[EXT_W-1:POS_W-1] == '0) || (v[EXT_W-1:POS_W-1] == '1)) begin
            r = v[POS_W-1:0];
        end else begin
            r = {v[EXT_W-1], {(POS_W-1){~v[EXT_W-1]}}};
        end
        return r;
    endfunction

endpackage

/* rtl/fge_ctrl.sv */
// ----------------------------------------------------------------------------
// fge_ctrl
// Sequencer: clear pass, view rectangle update, grid scan, result hand-off.
// ----------------------------------------------------------------------------
module fge_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fge_pkg::t_dp_status i_status,
    output fge_pkg::t_dp_cmd    o_cmd
);
    import fge_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // no request taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.fresh ? S_CLEAR : S_BOUND;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_BOUND;
                end
            end
            S_BOUND: begin
                o_cmd.bound = 1'b1;
                n_state     = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = i_status.overlap ? S_RECT_RD : S_SCAN;
            end
            S_RECT_RD: begin
                o_cmd.rect_rd = 1'b1;
                n_state       = S_RECT_WR;
            end
            S_RECT_WR: begin
                o_cmd.rect_wr = 1'b1;
                n_state       = i_status.rect_last ? S_SCAN : S_RECT_RD;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/fge_datapath.sv */
// ----------------------------------------------------------------------------
// fge_datapath
// Grid store, origin and bounds arithmetic, nearest border search, result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fge_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fge_pkg::t_dp_cmd              i_cmd,
    output fge_pkg::t_dp_status           o_status,
    input  logic [fge_pkg::POS_W-1:0]     i_pos_x,
    input  logic [fge_pkg::POS_W-1:0]     i_pos_y,
    input  logic                          i_cfg_valid,
    input  logic [fge_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fge_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_m_ready,
    output logic                          o_m_valid,
    output logic [fge_pkg::POS_W-1:0]     o_target_x,
    output logic [fge_pkg::POS_W-1:0]     o_target_y,
    output logic                          o_target_found,
    output logic                          o_map_complete,
    output logic [fge_pkg::CNT_W-1:0]     o_explored_count
);
    import fge_pkg::*;

    // control state
    logic                 r_ready;
    logic [CNT_W-1:0]     r_total;
    logic [POS_W-1:0]     r_origin_x;
    logic [POS_W-1:0]     r_origin_y;
    logic [FOV_W-1:0]     r_fov_x;
    logic [FOV_W-1:0]     r_fov_y;
    logic [ADDR_W-1:0]    r_idx;
    logic                 r_sv;
    logic                 r_found;
    logic                 r_ovld;

    // payload
    logic [POS_W-1:0]     r_px;
    logic [POS_W-1:0]     r_py;
    logic signed [CELL_W-1:0] r_imin, r_imax, r_jmin, r_jmax, r_ip, r_jp;
    logic [GRID_BITS-1:0] r_ilo, r_ihi, r_jlo, r_jhi, r_i, r_j;
    logic [ADDR_W-1:0]    r_sa;
    t_cell                r_rdata;
    logic [DIST_W-1:0]    r_best;
    logic [GRID_BITS-1:0] r_bi, r_bj;
    logic [POS_W-1:0]     r_tx, r_ty;
    logic                 r_tfound;
    logic                 r_tcomplete;
    logic [CNT_W-1:0]     r_tcount;

    t_cell                mem [NUM_CELLS];

    // ---------------------------------------------------------------- arithmetic
    logic [EXT_W-1:0]         org_x_ext, org_y_ext;
    logic signed [DIFF_W-1:0] px_e, py_e, ox_e, oy_e, hx_e, hy_e;
    logic signed [DIFF_W-1:0] d_imax, d_imin, d_jmax, d_jmin, d_ip, d_jp;

    assign org_x_ext = {{2{i_pos_x[POS_W-1]}}, i_pos_x} - EXT_W'(HALF_GRID);
    assign org_y_ext = {{2{i_pos_y[POS_W-1]}}, i_pos_y} - EXT_W'(HALF_GRID);

    assign px_e = {{(DIFF_W-POS_W){r_px[POS_W-1]}}, r_px};
    assign py_e = {{(DIFF_W-POS_W){r_py[POS_W-1]}}, r_py};
    assign ox_e = {{(DIFF_W-POS_W){r_origin_x[POS_W-1]}}, r_origin_x};
    assign oy_e = {{(DIFF_W-POS_W){r_origin_y[POS_W-1]}}, r_origin_y};
    assign hx_e = {{(DIFF_W-FOV_W){1'b0}}, r_fov_x};
    assign hy_e = {{(DIFF_W-FOV_W){1'b0}}, r_fov_y};

    assign d_imax = px_e + hx_e - ox_e;
    assign d_imin = px_e - hx_e - ox_e;
    assign d_jmax = py_e + hy_e - oy_e;
    assign d_jmin = py_e - hy_e - oy_e;
    assign d_ip   = px_e - ox_e;
    assign d_jp   = py_e - oy_e;

    logic overlap;
    assign overlap = !r_imax[CELL_W-1] && (r_imin <= CELL_MAX)
                  && !r_jmax[CELL_W-1] && (r_jmin <= CELL_MAX);

    // view rectangle cell update
    logic signed [CELL_W-1:0] i_s, j_s;
    logic                     on_edge;
    logic                     rect_last;
    logic                     rect_wen;
    assign i_s       = {{(CELL_W-GRID_BITS){1'b0}}, r_i};
    assign j_s       = {{(CELL_W-GRID_BITS){1'b0}}, r_j};
    assign on_edge   = (i_s == r_imin) || (i_s == r_imax) || (j_s == r_jmin) || (j_s == r_jmax);
    assign rect_last = (r_i == r_ihi) && (r_j == r_jhi);
    assign rect_wen  = i_cmd.rect_wr && (r_rdata != CELL_EXPLORED);

    // scan distance
    logic signed [CELL_W-1:0] si, sj, di, dj;
    logic signed [DIST_W-1:0] sq_i, sq_j;
    logic [DIST_W-1:0]        sq_dist;
    logic                     take;
    assign si      = {{(CELL_W-GRID_BITS){1'b0}}, r_sa[ADDR_W-1:GRID_BITS]};
    assign sj      = {{(CELL_W-GRID_BITS){1'b0}}, r_sa[GRID_BITS-1:0]};
    assign di      = si - r_ip;
    assign dj      = sj - r_jp;
    assign sq_i    = di * di;
    assign sq_j    = dj * dj;
    assign sq_dist = sq_i + sq_j;
    assign take    = r_sv && (r_rdata == CELL_BORDER) && (!r_found || (sq_dist < r_best));

    // result
    logic [EXT_W-1:0] tx_ext, ty_ext;
    assign tx_ext = {{2{r_origin_x[POS_W-1]}}, r_origin_x}
                  + {{(EXT_W-GRID_BITS-FRAC_BITS){1'b0}}, r_bi, {FRAC_BITS{1'b0}}};
    assign ty_ext = {{2{r_origin_y[POS_W-1]}}, r_origin_y}
                  + {{(EXT_W-GRID_BITS-FRAC_BITS){1'b0}}, r_bj, {FRAC_BITS{1'b0}}};

    // ---------------------------------------------------------------- control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= 1'b0;
            r_total    <= '0;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_fov_x    <= FOV_HALF_X_RST;
            r_fov_y    <= FOV_HALF_Y_RST;
            r_idx      <= '0;
            r_sv       <= 1'b0;
            r_found    <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FOV_HALF_X: r_fov_x <= i_cfg_data[FOV_W-1:0];
                    REG_FOV_HALF_Y: r_fov_y <= i_cfg_data[FOV_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                if (!r_ready) begin
                    r_ready    <= 1'b1;
                    r_total    <= '0;
                    r_origin_x <= sat_pos(org_x_ext);
                    r_origin_y <= sat_pos(org_y_ext);
                end
            end
            // clear pass wraps the index back to zero for the scan
            if (i_cmd.clear || i_cmd.scan_rd) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
            if (rect_wen && !on_edge) begin
                r_total <= r_total + CNT_W'(1);
            end
            r_sv <= i_cmd.scan_rd;
            if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovld <= 1'b1;
            end else if (i_m_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload regs
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
        if (i_cmd.bound) begin
            r_imax <= to_cell(d_imax);
            r_imin <= to_cell(d_imin);
            r_jmax <= to_cell(d_jmax);
            r_jmin <= to_cell(d_jmin);
            r_ip   <= to_cell(d_ip);
            r_jp   <= to_cell(d_jp);
        end
        if (i_cmd.clamp) begin
            r_ilo <= clamp_idx(r_imin);
            r_ihi <= clamp_idx(r_imax);
            r_jlo <= clamp_idx(r_jmin);
            r_jhi <= clamp_idx(r_jmax);
            r_i   <= clamp_idx(r_imin);
            r_j   <= clamp_idx(r_jmin);
        end
        if (i_cmd.rect_wr) begin
            if (r_j == r_jhi) begin
                r_j <= r_jlo;
                r_i <= r_i + GRID_BITS'(1);
            end else begin
                r_j <= r_j + GRID_BITS'(1);
            end
        end
        r_sa <= r_idx;
        if (take) begin
            r_best <= sq_dist;
            r_bi   <= r_sa[ADDR_W-1:GRID_BITS];
            r_bj   <= r_sa[GRID_BITS-1:0];
        end
        if (i_cmd.out_load) begin
            r_tx        <= r_found ? sat_pos(tx_ext) : r_px;
            r_ty        <= r_found ? sat_pos(ty_ext) : r_py;
            r_tfound    <= r_found;
            r_tcomplete <= (r_total == CNT_W'(NUM_CELLS));
            r_tcount    <= r_total;
        end
    end

    // ---------------------------------------------------------------- grid store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem[r_idx] <= CELL_UNEXPLORED;
        end else if (rect_wen) begin
            mem[{r_i, r_j}] <= on_edge ? CELL_BORDER : CELL_EXPLORED;
        end
        r_rdata <= mem[i_cmd.rect_rd ? {r_i, r_j} : r_idx];
    end

    assign o_status.fresh     = !r_ready;
    assign o_status.idx_last  = (r_idx == '1);
    assign o_status.overlap   = overlap;
    assign o_status.rect_last = rect_last;
    assign o_status.out_free  = !r_ovld || i_m_ready;

    assign o_m_valid        = r_ovld;
    assign o_target_x       = r_tx;
    assign o_target_y       = r_ty;
    assign o_target_found   = r_tfound;
    assign o_map_complete   = r_tcomplete;
    assign o_explored_count = r_tcount;

    `ASSERT_RST(a_total_max, i_clk, i_rst_n, r_total <= CNT_W'(NUM_CELLS),
        "explored count beyond grid")
    `ASSERT_RST(a_out_slot, i_clk, i_rst_n, i_cmd.out_load |-> (!r_ovld || i_m_ready),
        "result overwritten")
    `ASSERT_NEXT(a_first_init, i_clk, i_rst_n, i_cmd.load && !r_ready,
        r_ready && (r_total == '0), "grid not initialised")
    `ASSERT_RST(a_rect_range, i_clk, i_rst_n,
        i_cmd.rect_wr |-> ((r_i >= r_ilo) && (r_i <= r_ihi) && (r_j >= r_jlo) && (r_j <= r_jhi)),
        "rectangle walk out of range")

endmodule

/* rtl/frontier_grid_explore.sv */
// ----------------------------------------------------------------------------
// frontier_grid_explore
// Frontier exploration on a 16 x 16 cell grid; one target per position.
// ----------------------------------------------------------------------------
// Sequence: per position, each grid cell under the clamped view (0..256 cells)
//   is read, then updated; a scan of the grid then picks the nearest border.
// Flow: a new position is taken only in idle, once the previous result has been
//   loaded into the output register; the load waits on m_axis_tready if full.
// Reset: synchronous, active low; a clear pass over the grid store runs on the
//   first position after reset, configuration writes taken out of reset.
// ----------------------------------------------------------------------------
module frontier_grid_explore (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fge_pkg::IN_W-1:0]             s_axis_tdata,   // pos_x, pos_y
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // target_x, target_y, map_complete, explored_count, zero fill
    output logic [fge_pkg::OUT_W-1:0]            m_axis_tdata,
    output logic                                 m_axis_tuser,   // target_found
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fge_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fge_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import fge_pkg::*;

    t_dp_cmd          cmd;
    t_dp_status       status;
    logic [POS_W-1:0] tx, ty;
    logic             complete;
    logic [CNT_W-1:0] count;

    fge_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fge_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_pos_x          (s_axis_tdata[POS_W-1:0]),
        .i_pos_y          (s_axis_tdata[2*POS_W-1:POS_W]),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_m_ready        (m_axis_tready),
        .o_m_valid        (m_axis_tvalid),
        .o_target_x       (tx),
        .o_target_y       (ty),
        .o_target_found   (m_axis_tuser),
        .o_map_complete   (complete),
        .o_explored_count (count)
    );

    // register writes are held off while reset is asserted
    assign o_cfg_ready  = i_rst_n;
    assign m_axis_tdata = {{(OUT_W-2*POS_W-1-CNT_W){1'b0}}, count, complete, ty, tx};

endmodule
